FILE: rtl/mpcd_pkg.sv
// Package for the multichannel pulse counter driver.
// Holds channel constants, action and result codes, payload structs and
// the command/status bundles between controller and datapath. No dependencies.
package mpcd_pkg;

  // Channel count and the width of a channel number (fixed by the item field)
  localparam int unsigned CHANNELS = 16;
  localparam int unsigned CH_W     = 4;
  localparam int unsigned PIN_W    = 16;

  // Counter widths
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TIMER_W = 18;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned STEP_W  = 8;

  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 8'd2;
  localparam logic [CNT_W-1:0]  REPORT_CAP      = 32'h0000_FFFF;

  // Item actions
  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_SETUP     = 3'd1,
    ACT_ADD       = 3'd2,
    ACT_CLEAR     = 3'd3,
    ACT_CLEAR_ALL = 3'd4
  } action_e;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [2:0]        action;
    logic [CH_W-1:0]   channel;
    logic              enable;
    logic              active_high;
    logic [TIME_W-1:0] setup_time;
    logic [TIME_W-1:0] hold_time;
    logic [15:0]       add_count;
    logic              report_accept;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [CH_W-1:0]  report_channel;
    logic [15:0]      ack_count;
    logic [PIN_W-1:0] pin_levels;
    logic [PIN_W-1:0] pin_owned;
    logic             last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic            op_en;      // apply a non-tick item from the input payload
    logic            latch_en;   // capture tick qualifiers on transfer
    logic            walk_en;    // process one channel of a tick
    logic [CH_W-1:0] idx;        // channel being walked
    logic            status_en;  // load the closing pin status result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;             // output register can take a result this cycle
  } status_t;

endpackage

FILE: rtl/mpcd_ctrl.sv
// Controller for the multichannel pulse counter driver.
// Sequences item transfer, the per-channel tick walk and the closing status
// result. Depends on mpcd_pkg.
module mpcd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [2:0]       action_i,
  output logic             in_ready_o,
  input  mpcd_pkg::status_t sts_i,
  output mpcd_pkg::cmd_t   cmd_o
);
  import mpcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_STATUS
  } state_e;

  state_e          state_q, state_d;
  logic [CH_W-1:0] idx_q, idx_d;
  logic            in_xfer;
  logic            is_tick;
  logic            idx_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_tick    = (action_i == ACT_TICK);
  assign idx_last   = (int'(idx_q) == int'(CHANNELS) - 1);

  // Commands and next state
  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    cmd_o           = '0;
    cmd_o.idx       = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.latch_en = 1'b1;
          cmd_o.op_en    = !is_tick;
          idx_d          = '0;
          state_d        = is_tick ? ST_WALK : ST_STATUS;
        end
      end
      ST_WALK: begin
        if (sts_i.slot_free) begin
          cmd_o.walk_en = 1'b1;
          if (idx_last) begin
            state_d = ST_STATUS;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_STATUS: begin
        if (sts_i.slot_free) begin
          cmd_o.status_en = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

FILE: rtl/mpcd_datapath.sv
// Datapath for the multichannel pulse counter driver.
// Per-channel state, tick arithmetic, the tick_step register and the output
// result register. Depends on mpcd_pkg.
module mpcd_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mpcd_pkg::cmd_t        cmd_i,
  output mpcd_pkg::status_t     sts_o,
  input  mpcd_pkg::in_item_t    in_item_i,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output mpcd_pkg::out_item_t   out_item_o
);
  import mpcd_pkg::*;

  // Per-channel flags (read everywhere for pin status)
  logic [CHANNELS-1:0] enabled_q, polarity_q, active_q;
  // Per-channel words (read at one address)
  logic [TIME_W-1:0]  setup_q [CHANNELS];
  logic [TIME_W-1:0]  hold_q  [CHANNELS];
  logic [CNT_W-1:0]   pend_q  [CHANNELS];
  logic [CNT_W-1:0]   done_q  [CHANNELS];
  logic [TIMER_W-1:0] timer_q [CHANNELS];

  logic [STEP_W-1:0] step_q;
  logic              accept_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [CH_W-1:0]    addr;
  logic               ch_ok;
  logic               rd_en;
  logic [CNT_W-1:0]   rd_pend, rd_done;
  logic [TIMER_W-1:0] rd_timer;
  logic [TIME_W-1:0]  rd_setup, rd_hold;

  logic               wr_en, wr_enabled, wr_pol, wr_active;
  logic [TIME_W-1:0]  wr_setup, wr_hold;
  logic [CNT_W-1:0]   wr_pend, wr_done;
  logic [TIMER_W-1:0] wr_timer;
  logic               clr_all;

  logic               has_rep;
  logic [15:0]        rep_cnt;
  logic [CNT_W-1:0]   done_red;
  logic [TIMER_W-1:0] t_next;
  logic [TIME_W:0]    pulse_end;
  logic [CNT_W:0]     add_sum;

  logic [PIN_W-1:0]   levels, owned;
  logic               slot_free;

  assign slot_free       = !out_valid_q || out_ready_i;
  assign sts_o.slot_free = slot_free;

  assign addr  = cmd_i.walk_en ? cmd_i.idx : in_item_i.channel;
  assign ch_ok = (int'(in_item_i.channel) < int'(CHANNELS));

  assign rd_en    = enabled_q[addr];
  assign rd_pend  = pend_q[addr];
  assign rd_done  = done_q[addr];
  assign rd_timer = timer_q[addr];
  assign rd_setup = setup_q[addr];
  assign rd_hold  = hold_q[addr];

  // Report of the walked channel, capped to 16 bits
  assign has_rep = rd_en && (rd_done != '0);
  assign rep_cnt = (rd_done >= REPORT_CAP) ? 16'hFFFF : rd_done[15:0];
  always_comb begin
    if (!accept_q) begin
      done_red = rd_done;
    end else if (rd_done >= REPORT_CAP) begin
      done_red = rd_done - REPORT_CAP;
    end else begin
      done_red = '0;
    end
  end

  // Phase timer wraps at 18 bits
  assign t_next    = rd_timer + TIMER_W'(step_q);
  assign pulse_end = {1'b0, rd_setup} + {1'b0, rd_hold};
  assign add_sum   = {1'b0, rd_pend} + (CNT_W + 1)'(in_item_i.add_count);

  // Next values of the addressed entry
  always_comb begin
    wr_en      = 1'b0;
    wr_enabled = rd_en;
    wr_pol     = polarity_q[addr];
    wr_active  = active_q[addr];
    wr_setup   = rd_setup;
    wr_hold    = rd_hold;
    wr_pend    = rd_pend;
    wr_done    = rd_done;
    wr_timer   = rd_timer;
    clr_all    = 1'b0;
    if (cmd_i.walk_en && rd_en) begin
      wr_en   = 1'b1;
      wr_done = done_red;
      if (rd_pend != '0) begin
        if (t_next < TIMER_W'(rd_setup)) begin
          wr_timer  = t_next;
          wr_active = 1'b0;
        end else if (t_next < TIMER_W'(pulse_end)) begin
          wr_timer  = t_next;
          wr_active = 1'b1;
        end else begin
          wr_pend   = rd_pend - 1'b1;
          wr_timer  = '0;
          wr_active = 1'b0;
          if (done_red != '1) begin
            wr_done = done_red + 1'b1;
          end
        end
      end
    end else if (cmd_i.op_en) begin
      unique case (in_item_i.action)
        ACT_SETUP: begin
          wr_en      = ch_ok;
          wr_enabled = in_item_i.enable;
          wr_pol     = in_item_i.active_high;
          wr_setup   = in_item_i.setup_time;
          wr_hold    = in_item_i.hold_time;
          wr_pend    = '0;
          wr_done    = '0;
          wr_timer   = '0;
          wr_active  = 1'b0;
        end
        ACT_ADD: begin
          wr_en   = ch_ok;
          wr_pend = add_sum[CNT_W] ? '1 : add_sum[CNT_W-1:0];
        end
        ACT_CLEAR: begin
          wr_en     = ch_ok;
          wr_pend   = '0;
          wr_timer  = '0;
          wr_active = 1'b0;
        end
        ACT_CLEAR_ALL: clr_all = 1'b1;
        default: ;
      endcase
    end
  end

  // Channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= '0;
      polarity_q <= '0;
      active_q   <= '0;
      for (int i = 0; i < int'(CHANNELS); i++) begin
        setup_q[i] <= '0;
        hold_q[i]  <= '0;
        pend_q[i]  <= '0;
        done_q[i]  <= '0;
        timer_q[i] <= '0;
      end
    end else if (clr_all) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        if (enabled_q[i]) begin
          pend_q[i]   <= '0;
          active_q[i] <= 1'b0;
        end
      end
    end else if (wr_en) begin
      enabled_q[addr]  <= wr_enabled;
      polarity_q[addr] <= wr_pol;
      active_q[addr]   <= wr_active;
      setup_q[addr]    <= wr_setup;
      hold_q[addr]     <= wr_hold;
      pend_q[addr]     <= wr_pend;
      done_q[addr]     <= wr_done;
      timer_q[addr]    <= wr_timer;
    end
  end

  // Tick step register and tick qualifier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= TICK_STEP_RESET;
      accept_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (cmd_i.latch_en) begin
        accept_q <= in_item_i.report_accept;
      end
    end
  end

  // Pin levels and ownership of the first sixteen channels
  always_comb begin
    levels = '0;
    owned  = '0;
    for (int i = 0; i < int'(CHANNELS) && i < int'(PIN_W); i++) begin
      owned[i]  = enabled_q[i];
      levels[i] = enabled_q[i] && (active_q[i] ? polarity_q[i] : !polarity_q[i]);
    end
  end

  // Output result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.walk_en && has_rep) || cmd_i.status_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_en && has_rep) begin
      out_q.kind           <= KIND_REPORT;
      out_q.report_channel <= cmd_i.idx;
      out_q.ack_count      <= rep_cnt;
      out_q.pin_levels     <= levels;
      out_q.pin_owned      <= owned;
      out_q.last           <= 1'b0;
    end else if (cmd_i.status_en) begin
      out_q.kind           <= KIND_STATUS;
      out_q.report_channel <= '0;
      out_q.ack_count      <= '0;
      out_q.pin_levels     <= levels;
      out_q.pin_owned      <= owned;
      out_q.last           <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: rtl/multichannel_pulse_counter_driver.sv
// Top level of the multichannel pulse counter driver.
// Joins mpcd_ctrl and mpcd_datapath. Depends on mpcd_pkg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------
//   input    | in_valid_i/in_ready_o | in_item_i  (in_item_t)
//   result   | out_valid_o/out_ready_i | out_item_o (out_item_t)
//   config   | cfg_we_i              | cfg_wdata_i (tick_step)
//
// A tick walks the channel entries in order after the transfer, one entry
// per cycle while the output register is free, then loads the pin status
// result. Every other item goes straight to its status result. Each result
// waits for a free output register, so a stalled result port delays it.
// Reset (rst_ni low, asynchronous) clears all channel state; tick_step = 2.
module multichannel_pulse_counter_driver (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mpcd_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mpcd_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i
);
  import mpcd_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Sequencer
  mpcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_item_i.action),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Channel state and results
  mpcd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/mpcd_checker.sv
// Port-level checks for the multichannel pulse counter driver, with the
// bind that attaches them to the top level. Depends on mpcd_pkg.
module mpcd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mpcd_pkg::out_item_t out_item_o
);
  import mpcd_pkg::*;

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transfer");

  // Only one item in flight: ready drops after each input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // Reports are never last, status results always are
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.kind != out_item_o.last))
    else $error("kind and last disagree");

  // An undriven pin never shows a level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.pin_levels & ~out_item_o.pin_owned) == '0))
    else $error("pin level on a channel that is not enabled");

endmodule

bind multichannel_pulse_counter_driver mpcd_checker u_mpcd_checker (.*);

FILE: tb/tb_multichannel_pulse_counter_driver.sv
// Self-checking testbench for multichannel_pulse_counter_driver.
// Drives command transfers, predicts pulse reports and pin status, and checks every result.
// Depends on mpcd_pkg and the RTL of the block only.
module tb_multichannel_pulse_counter_driver;
  import mpcd_pkg::*;

  // Action codes that the block must ignore
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  localparam int HOLD_AT     = 150;  // result count at which the sink stalls for long
  localparam int HOLD_CYCLES = 100;
  localparam int DRAIN_WAIT  = 2 * CHANNELS;

  localparam int         PHASE_ITEMS [4] = '{60, 70, 25, 90};
  localparam logic [7:0] PHASE_STEP  [4] = '{8'd1, 8'd255, 8'd0, 8'd0};

  typedef struct {
    in_item_t    item;
    bit          typed;
    logic [15:0] lv;
    logic [15:0] ow;
  } row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  int tx_max = 4;
  int rx_max = 4;
  int errors = 0;

  // Predicted channel state
  logic              ch_en    [CHANNELS] = '{default: 1'b0};
  logic              ch_pol   [CHANNELS] = '{default: 1'b0};
  logic [TIME_W-1:0] ch_setup [CHANNELS] = '{default: '0};
  logic [TIME_W-1:0] ch_hold  [CHANNELS] = '{default: '0};
  logic [CNT_W-1:0]  ch_pend  [CHANNELS] = '{default: '0};
  logic [CNT_W-1:0]  ch_done  [CHANNELS] = '{default: '0};
  logic [TIMER_W-1:0] ch_timer [CHANNELS] = '{default: '0};
  logic              ch_act   [CHANNELS] = '{default: 1'b0};
  logic [STEP_W-1:0] tick_step_q = TICK_STEP_RESET;

  out_item_t due_results [$];
  row_t      script [$];

  multichannel_pulse_counter_driver u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result as the block would present it now, with the current pin picture
  function automatic out_item_t snapshot(logic kind, logic [CH_W-1:0] chan,
                                         logic [15:0] count, logic fin);
    out_item_t r;
    r = '0;
    r.kind           = kind;
    r.report_channel = chan;
    r.ack_count      = count;
    r.last           = fin;
    for (int i = 0; i < PIN_W; i++) begin
      if (ch_en[i]) begin
        r.pin_owned[i]  = 1'b1;
        r.pin_levels[i] = ch_act[i] ? ch_pol[i] : ~ch_pol[i];
      end
    end
    return r;
  endfunction

  // Apply one command to the predicted state and queue the results it gives
  task automatic step_channels(input in_item_t it);
    logic [CNT_W-1:0]   a;
    logic [CNT_W:0]     s;
    logic [TIMER_W-1:0] span;
    case (it.action)
      ACT_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch_en[i]) begin
            // report first, then advance the waveform of this channel
            if (ch_done[i] != '0) begin
              a = ch_done[i];
              if (it.report_accept) ch_done[i] = (a >= REPORT_CAP) ? a - REPORT_CAP : '0;
              due_results.push_back(snapshot(KIND_REPORT, CH_W'(i),
                                    (a >= REPORT_CAP) ? REPORT_CAP[15:0] : a[15:0], 1'b0));
            end
            if (ch_pend[i] != '0) begin
              span = ch_setup[i] + ch_hold[i];
              ch_timer[i] = ch_timer[i] + tick_step_q;
              if (ch_timer[i] < ch_setup[i]) begin
                ch_act[i] = 1'b0;
              end else if (ch_timer[i] < span) begin
                ch_act[i] = 1'b1;
              end else begin
                ch_pend[i]  = ch_pend[i] - 1;
                ch_timer[i] = '0;
                ch_act[i]   = 1'b0;
                if (ch_done[i] != '1) ch_done[i] = ch_done[i] + 1;
              end
            end
          end
        end
      end
      ACT_SETUP: begin
        ch_en[it.channel]    = it.enable;
        ch_pol[it.channel]   = it.active_high;
        ch_setup[it.channel] = it.setup_time;
        ch_hold[it.channel]  = it.hold_time;
        ch_pend[it.channel]  = '0;
        ch_done[it.channel]  = '0;
        ch_timer[it.channel] = '0;
        ch_act[it.channel]   = 1'b0;
      end
      ACT_ADD: begin
        s = {1'b0, ch_pend[it.channel]} + it.add_count;
        ch_pend[it.channel] = s[CNT_W] ? '1 : s[CNT_W-1:0];
      end
      ACT_CLEAR: begin
        ch_pend[it.channel]  = '0;
        ch_timer[it.channel] = '0;
        ch_act[it.channel]   = 1'b0;
      end
      ACT_CLEAR_ALL: begin
        // phase timers survive a clear all
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch_en[i]) begin
            ch_pend[i] = '0;
            ch_act[i]  = 1'b0;
          end
        end
      end
      default: ;
    endcase
    due_results.push_back(snapshot(KIND_STATUS, '0, '0, 1'b1));
  endtask

  function automatic in_item_t cmd(logic [2:0] op, logic [CH_W-1:0] chan, logic en,
                                   logic ah, logic [15:0] su, logic [15:0] ho,
                                   logic [15:0] cnt, logic acc);
    in_item_t it;
    it.action        = op;
    it.channel       = chan;
    it.enable        = en;
    it.active_high   = ah;
    it.setup_time    = su;
    it.hold_time     = ho;
    it.add_count     = cnt;
    it.report_accept = acc;
    return it;
  endfunction

  // Mostly channel set-ups, adds and ticks with short pulses; some full-range values
  function automatic in_item_t rand_item();
    in_item_t   it;
    logic [63:0] raw;
    int         r;
    raw = {$urandom, $urandom};
    it  = raw[$bits(in_item_t)-1:0];
    r   = $urandom_range(0, 99);
    if (r < 45)      it.action = ACT_TICK;
    else if (r < 65) it.action = ACT_ADD;
    else if (r < 80) it.action = ACT_SETUP;
    else if (r < 89) it.action = ACT_CLEAR;
    else if (r < 94) it.action = ACT_CLEAR_ALL;
    else             it.action = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
    if ($urandom_range(0, 7) != 0) begin
      it.setup_time = 16'($urandom_range(0, 6));
      it.hold_time  = 16'($urandom_range(0, 6));
      it.add_count  = 16'($urandom_range(0, 4));
    end
    if ($urandom_range(0, 3) != 0) it.enable = 1'b1;
    return it;
  endfunction

  // Offer one command and predict its results once the transfer happens
  task automatic send_item(input in_item_t it, input bit typed,
                           input logic [15:0] lv, input logic [15:0] ow);
    int        gap;
    out_item_t t;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    step_channels(it);
    if (typed) begin
      t = '0;
      t.kind       = KIND_STATUS;
      t.pin_levels = lv;
      t.pin_owned  = ow;
      t.last       = 1'b1;
      due_results[due_results.size()-1] = t;
    end
  endtask

  // Register write, only once every result has been taken
  task automatic write_step(input logic [7:0] v);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we      <= 1'b0;
    tick_step_q = v;
  endtask

  // Result sink with random stalls and one long hold-off
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, rx_max);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result with nothing expected: %h", out_item);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_item.kind != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
          errors++;
        end
        if (out_item.report_channel != want.report_channel) begin
          $error("report_channel: expected %0d, got %0d",
                 want.report_channel, out_item.report_channel);
          errors++;
        end
        if (out_item.ack_count != want.ack_count) begin
          $error("ack_count: expected %0d, got %0d", want.ack_count, out_item.ack_count);
          errors++;
        end
        if (out_item.pin_levels != want.pin_levels) begin
          $error("pin_levels: expected %h, got %h", want.pin_levels, out_item.pin_levels);
          errors++;
        end
        if (out_item.pin_owned != want.pin_owned) begin
          $error("pin_owned: expected %h, got %h", want.pin_owned, out_item.pin_owned);
          errors++;
        end
        if (out_item.last != want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #800000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    // Directed commands; the first rows carry their status result by hand
    script.push_back('{cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 1), 1'b1, 16'h0000, 16'h0000});
    script.push_back('{cmd(ACT_RSVD7, 15, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1),
                       1'b1, 16'h0000, 16'h0000});
    script.push_back('{cmd(ACT_SETUP, 0, 1, 1, 0, 0, 0, 0), 1'b1, 16'h0000, 16'h0001});
    script.push_back('{cmd(ACT_SETUP, 15, 1, 0, 16'hFFFF, 16'hFFFF, 0, 0),
                       1'b1, 16'h8000, 16'h8001});
    script.push_back('{cmd(ACT_ADD, 0, 0, 0, 0, 0, 3, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_ADD, 15, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0, '0});  // refused
    script.push_back('{cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0, '0});  // accepted
    script.push_back('{cmd(ACT_SETUP, 5, 1, 1, 2, 4, 0, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_ADD, 5, 0, 0, 0, 0, 2, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_RSVD5, 5, 0, 0, 0, 0, 9, 1), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_CLEAR, 15, 0, 0, 0, 0, 0, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_CLEAR, 3, 0, 0, 0, 0, 0, 0), 1'b0, '0, '0});  // disabled
    script.push_back('{cmd(ACT_ADD, 3, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_SETUP, 0, 0, 1, 16'hFFFF, 0, 0, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_RSVD6, 0, 1, 0, 0, 0, 0, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_ADD, 5, 0, 0, 0, 0, 0, 0), 1'b0, '0, '0});
    script.push_back('{cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0, '0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) send_item(script[k].item, script[k].typed, script[k].lv, script[k].ow);

    // Random phases at the step extremes, zero, and a mid value
    for (int ph = 0; ph < 4; ph++) begin
      write_step(ph == 3 ? 8'($urandom_range(2, 254)) : PHASE_STEP[ph]);
      for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
        if (n % 16 == 0) begin
          tx_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
          rx_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
        end
        send_item(rand_item(), 1'b0, '0, '0);
      end
    end

    // Drain, then watch a little longer for stray results
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mpcd_pkg.sv
rtl/mpcd_ctrl.sv
rtl/mpcd_datapath.sv
rtl/multichannel_pulse_counter_driver.sv
rtl/mpcd_checker.sv
tb/tb_multichannel_pulse_counter_driver.sv
